// File: design/barometric_apogee_detector_macros.svh
// assertion macros for the barometric apogee detector
`ifndef BAROMETRIC_APOGEE_DETECTOR_MACROS_SVH
`define BAROMETRIC_APOGEE_DETECTOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BAPD_ASSERT_NOW(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("bapd assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BAPD_ASSERT_NEXT(name, cond, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("bapd assertion failed");

`endif

// File: design/bapd_pkg.sv
// shared types and constants of the barometric apogee detector
package bapd_pkg;

	localparam int PRESS_W       = 17;
	localparam int ACCEL_W       = 15;
	localparam int ALPHA_W       = 9;
	localparam int ALPHA_FRAC    = 8;
	localparam int THRESH_W      = 14;
	localparam int MARGIN_W      = 16;
	localparam int PHASE_W       = 2;
	localparam int REG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 17;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 40;
	localparam int FRACTION_BITS_DEF = 8;

	// flight phase codes
	localparam logic [PHASE_W-1:0] PHASE_READY   = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_ASCENT  = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_DESCENT = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_GROUND = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_ALPHA  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THRESH = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_MARGIN = 2'd3;

	// register reset values
	localparam logic [PRESS_W-1:0]  GROUND_RST = 17'd101325;
	localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 9'd77;
	localparam logic [THRESH_W-1:0] THRESH_RST = 14'd2000;
	localparam logic [MARGIN_W-1:0] MARGIN_RST = 16'd300;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               launch;
		logic               apogee;
	} phase_res_t;

endpackage

// File: design/bapd_ema.sv
// exponential smoothing step: s + alpha * ((p << F) - s) / 256, floored
module bapd_ema
	import bapd_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic [ALPHA_W-1:0]               alpha,
	input  logic [PRESS_W-1:0]               pressure,
	input  logic [PRESS_W+FRACTION_BITS-1:0] smoothed_cur,
	output logic [PRESS_W+FRACTION_BITS-1:0] smoothed_next
);

	localparam int PW = PRESS_W + FRACTION_BITS;
	localparam int DW = PW + 1;
	localparam int MW = DW + ALPHA_W + 1;

	logic [ALPHA_W-1:0]  alpha_sat;
	logic signed [ALPHA_W:0] alpha_s;
	logic signed [DW-1:0] diff;
	logic signed [MW-1:0] prod;
	logic signed [MW-1:0] step;

	// anything above one saturates to one
	assign alpha_sat = alpha[ALPHA_W-1] ? ALPHA_ONE : alpha;
	assign alpha_s   = $signed({1'b0, alpha_sat});
	assign diff      = $signed({1'b0, pressure, {FRACTION_BITS{1'b0}}})
		- $signed({1'b0, smoothed_cur});
	assign prod      = alpha_s * diff;
	assign step      = prod >>> ALPHA_FRAC;

	// the true result stays in range, so modulo arithmetic is exact
	assign smoothed_next = smoothed_cur + step[PW-1:0];

endmodule

// File: design/bapd_phase.sv
// flight phase transitions, minimum tracking and event flags
module bapd_phase
	import bapd_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic [PHASE_W-1:0]               phase_cur,
	input  logic [PRESS_W+FRACTION_BITS-1:0] smoothed_next,
	input  logic [PRESS_W+FRACTION_BITS-1:0] minimum_cur,
	input  logic signed [ACCEL_W-1:0]        accel,
	input  logic [THRESH_W-1:0]              threshold,
	input  logic [MARGIN_W-1:0]              margin,
	output logic [PRESS_W+FRACTION_BITS-1:0] minimum_next,
	output phase_res_t                       res
);

	localparam int PW = PRESS_W + FRACTION_BITS;

	logic                      launch_hit;
	logic [PW-1:0]             min_track;
	logic [PW:0]               apogee_level;
	logic                      apogee_hit;

	assign launch_hit   = accel > $signed({1'b0, threshold});
	assign min_track    = (smoothed_next < minimum_cur) ? smoothed_next : minimum_cur;
	assign apogee_level = {1'b0, min_track}
		+ {{(PW + 1 - MARGIN_W - FRACTION_BITS){1'b0}}, margin, {FRACTION_BITS{1'b0}}};
	assign apogee_hit   = {1'b0, smoothed_next} > apogee_level;

	always_comb begin
		res          = '{phase: phase_cur, launch: 1'b0, apogee: 1'b0};
		minimum_next = minimum_cur;
		unique case (phase_cur)
			PHASE_READY: begin
				if (launch_hit) begin
					res.phase    = PHASE_ASCENT;
					res.launch   = 1'b1;
					minimum_next = smoothed_next;
				end
			end
			PHASE_ASCENT: begin
				minimum_next = min_track;
				if (apogee_hit) begin
					res.phase  = PHASE_DESCENT;
					res.apogee = 1'b1;
				end
			end
			default: begin
				// descent holds; the unused code goes to descent
				res.phase = PHASE_DESCENT;
			end
		endcase
	end

endmodule

// File: design/barometric_apogee_detector.sv
// barometric apogee detector top level
// path: input transaction to earliest result transaction (input reg, then result reg)
// throughput: one sample per cycle; the smoothing multiply-add and phase compares sit
//   between the two registers, so every cycle can take a sample unless the output stalls
// reset: arst_n clears valids, loads default registers, phase ready, pressures to ground
// writing ground_pressure re-arms: phase ready, smoothed and minimum to the new ground
`include "barometric_apogee_detector_macros.svh"

module barometric_apogee_detector
	import bapd_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   wr_en,
	input  logic [REG_IDX_W-1:0]   wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	// sample stream in
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // pressure_sample[16:0], vertical_accel[31:17]
	// result stream out
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // flight_phase[1:0], smoothed_pressure[18:2],
	                                              // lowest_pressure[35:19], launch_event[36],
	                                              // apogee_event[37], zero[39:38]
);

	localparam int PW = PRESS_W + FRACTION_BITS;

	// configuration registers
	logic [ALPHA_W-1:0]  alpha_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [MARGIN_W-1:0] margin_q;

	// detector state
	logic [PHASE_W-1:0]  phase_q;
	logic [PW-1:0]       smooth_q;
	logic [PW-1:0]       min_q;

	// input register
	logic                       valid_s1;
	logic [PRESS_W-1:0]         pressure_s1;
	logic signed [ACCEL_W-1:0]  accel_s1;

	// result register
	logic                valid_s2;
	phase_res_t          res_s2;
	logic [PRESS_W-1:0]  smooth_s2;
	logic [PRESS_W-1:0]  min_s2;

	logic          out_free;
	logic          advance;
	logic          rearm;
	logic [PW-1:0] smooth_next;
	logic [PW-1:0] min_next;
	phase_res_t    res_next;

	// result slot frees when empty or taken this cycle
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || advance;
	assign rearm         = wr_en && (wr_index == REG_GROUND);

	// configuration writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= ALPHA_RST;
			thresh_q <= THRESH_RST;
			margin_q <= MARGIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				// ground value only feeds the re-arm of the detector state
				REG_GROUND: ;
				REG_ALPHA:  alpha_q  <= wr_data[ALPHA_W-1:0];
				REG_THRESH: thresh_q <= wr_data[THRESH_W-1:0];
				REG_MARGIN: margin_q <= wr_data[MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: takes a transaction whenever the slot drains or is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pressure_s1 <= s_axis_tdata[PRESS_W-1:0];
			accel_s1    <= $signed(s_axis_tdata[PRESS_W +: ACCEL_W]);
		end
	end

	// smoothing step
	bapd_ema #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_ema (
		.alpha         (alpha_q),
		.pressure      (pressure_s1),
		.smoothed_cur  (smooth_q),
		.smoothed_next (smooth_next)
	);

	// phase decision on the freshly smoothed value
	bapd_phase #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_phase (
		.phase_cur     (phase_q),
		.smoothed_next (smooth_next),
		.minimum_cur   (min_q),
		.accel         (accel_s1),
		.threshold     (thresh_q),
		.margin        (margin_q),
		.minimum_next  (min_next),
		.res           (res_next)
	);

	// detector state: re-arm on a ground write, else update when a sample retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PHASE_READY;
			smooth_q <= {GROUND_RST, {FRACTION_BITS{1'b0}}};
			min_q    <= {GROUND_RST, {FRACTION_BITS{1'b0}}};
		end else if (rearm) begin
			phase_q  <= PHASE_READY;
			smooth_q <= {wr_data[PRESS_W-1:0], {FRACTION_BITS{1'b0}}};
			min_q    <= {wr_data[PRESS_W-1:0], {FRACTION_BITS{1'b0}}};
		end else if (advance) begin
			phase_q  <= res_next.phase;
			smooth_q <= smooth_next;
			min_q    <= min_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2    <= res_next;
			smooth_s2 <= smooth_next[PW-1:FRACTION_BITS];
			min_s2    <= min_next[PW-1:FRACTION_BITS];
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.apogee, res_s2.launch, min_s2, smooth_s2,
		res_s2.phase};

	// both events never come from one sample
	`BAPD_ASSERT_NOW(a_one_event, valid_s2, !(res_s2.launch && res_s2.apogee))
	// a launch transaction reports ascent
	`BAPD_ASSERT_NOW(a_launch_phase, valid_s2 && res_s2.launch, res_s2.phase == PHASE_ASCENT)
	// descent holds until re-armed
	`BAPD_ASSERT_NEXT(a_descent_hold, (phase_q == PHASE_DESCENT) && !rearm,
		phase_q == PHASE_DESCENT)
	// during ascent the minimum never sits above the smoothed value
	`BAPD_ASSERT_NOW(a_min_bound, phase_q == PHASE_ASCENT, min_q <= smooth_q)

endmodule
